FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the IMA ADPCM block decoder RTL.
// Each macro expects signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ima_pkg.sv
// Package for the IMA ADPCM block decoder: types, register map, tables.
// No dependencies; imported by every module of the block.
`default_nettype none

package ima_pkg;

	// Register map (index = paddr[3:2])
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_ALIGN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BYTE_COUNT   = 2'd2;

	localparam logic [6:0] IDX_MAX = 7'd88;
	localparam logic [15:0] MIN_BLOCK_ALIGN = 16'd5;
	localparam logic [31:0] MIN_SAMPLE_LIMIT = 32'd4;
	localparam logic [31:0] HDR_BYTES = 32'd4;

	localparam logic [14:0] STEP_TAB [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
		15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
		15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
		15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
		15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
		15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
		15'd29794, 15'd32767
	};

	localparam logic signed [4:0] IDX_ADJ [0:7] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

	// Configuration register set
	typedef struct packed {
		logic [15:0] block_align;
		logic [31:0] sample_limit;
		logic [31:0] byte_count;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_of_byte;
		logic               final_res;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ima_nibble.sv
// Single IMA ADPCM nibble decode: step lookup, difference, saturate, index adapt.
// Depends on ima_pkg (step and index tables).
`default_nettype none

module ima_nibble (
	input  wire logic signed [15:0] pred,
	input  wire logic [6:0]         idx,
	input  wire logic [3:0]         nib,
	output logic signed [15:0]      pred_new,
	output logic [6:0]              idx_new
);
	import ima_pkg::*;

	logic [6:0]         idx_c;
	logic [14:0]        step;
	logic [16:0]        diff;
	logic signed [17:0] sum;
	logic signed [8:0]  ni;

	// Difference from the three magnitude bits
	always_comb begin
		idx_c = (idx > IDX_MAX) ? IDX_MAX : idx;
		step  = STEP_TAB[idx_c];
		diff  = {5'd0, step[14:3]};
		if (nib[0]) diff = diff + {4'd0, step[14:2]};
		if (nib[1]) diff = diff + {3'd0, step[14:1]};
		if (nib[2]) diff = diff + {2'd0, step};
	end

	// Apply sign and saturate to 16 bits
	always_comb begin
		if (nib[3]) sum = 18'(pred) - $signed({1'b0, diff});
		else        sum = 18'(pred) + $signed({1'b0, diff});
		if (sum > 18'sd32767)       pred_new = 16'sh7FFF;
		else if (sum < -18'sd32768) pred_new = -16'sh8000;
		else                        pred_new = sum[15:0];
	end

	// Step index adaptation, clamped to 0..88
	always_comb begin
		ni = $signed({2'b00, idx_c}) + 9'(IDX_ADJ[nib[2:0]]);
		if (ni < 9'sd0)                          idx_new = 7'd0;
		else if (ni > $signed({2'b00, IDX_MAX})) idx_new = IDX_MAX;
		else                                     idx_new = ni[6:0];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ima_ctrl.sv
// IMA ADPCM block sequencer: header parse, counters, one nibble per cycle when slot_free.
// Depends on ima_pkg, ima_nibble and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ima_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ima_pkg::cfg_t cfg,
	input  wire logic          item_valid,
	input  wire logic [7:0]    item_byte,
	input  wire logic          item_start,
	input  wire logic          slot_free,
	output logic               consume,
	output logic               emit,
	output ima_pkg::res_t      res
);
	import ima_pkg::*;

	// Decoder state
	logic signed [15:0] predictor_q;
	logic [6:0]         step_index_q;
	logic [15:0]        block_pos_q;
	logic [7:0]         hdr_low_q;
	logic [31:0]        bytes_left_q;
	logic [31:0]        samples_done_q;
	logic               halted_q;
	logic               phase_q;

	// Effective state seen by this item (start request restarts)
	logic               strt, bad_cfg, act;
	logic signed [15:0] e_pred;
	logic [6:0]         e_idx;
	logic [15:0]        e_pos;
	logic [7:0]         e_hlo;
	logic [31:0]        e_bl, e_sd, sd_inc, bl_dec;
	logic               e_halt, endblk, more;

	// Next state
	logic signed [15:0] n_pred;
	logic [6:0]         n_idx;
	logic [15:0]        n_pos;
	logic [7:0]         n_hlo;
	logic [31:0]        n_bl, n_sd;
	logic               n_halt, n_phase;

	logic signed [15:0] dec_pred;
	logic [6:0]         dec_idx;

	ima_nibble u_nibble (
		.pred     (e_pred),
		.idx      (e_idx),
		.nib      (phase_q ? item_byte[7:4] : item_byte[3:0]),
		.pred_new (dec_pred),
		.idx_new  (dec_idx)
	);

	// Restart values on a start request
	always_comb begin
		strt    = item_start && !phase_q;
		bad_cfg = (cfg.sample_limit < MIN_SAMPLE_LIMIT) || (cfg.block_align < MIN_BLOCK_ALIGN)
			|| ({16'd0, cfg.block_align} > cfg.byte_count);
		e_pred  = strt ? 16'sd0 : predictor_q;
		e_idx   = strt ? 7'd0 : step_index_q;
		e_pos   = strt ? 16'd0 : block_pos_q;
		e_hlo   = strt ? 8'd0 : hdr_low_q;
		e_bl    = strt ? cfg.byte_count : bytes_left_q;
		e_sd    = strt ? 32'd0 : samples_done_q;
		e_halt  = strt ? bad_cfg : halted_q;
		sd_inc  = e_sd + 32'd1;
		bl_dec  = e_bl - 32'd1;
		endblk  = ({1'b0, e_pos} + 17'd1) >= {1'b0, cfg.block_align};
	end

	// Per-item sequencing
	always_comb begin
		act     = 1'b0;
		consume = 1'b0;
		emit    = 1'b0;
		more    = 1'b0;
		res     = '0;
		n_pred  = e_pred;
		n_idx   = e_idx;
		n_pos   = e_pos;
		n_hlo   = e_hlo;
		n_bl    = e_bl;
		n_sd    = e_sd;
		n_halt  = e_halt;
		n_phase = phase_q;
		if (item_valid) begin
			if (phase_q) begin
				// high nibble, closes the byte
				if (slot_free) begin
					act     = 1'b1;
					consume = 1'b1;
					emit    = 1'b1;
					more    = (sd_inc < cfg.sample_limit)
						&& (endblk ? (bl_dec > HDR_BYTES) : (bl_dec != 32'd0));
					res     = '{sample: dec_pred, last_of_byte: 1'b1, final_res: !more};
					n_pred  = dec_pred;
					n_idx   = dec_idx;
					n_sd    = sd_inc;
					n_bl    = bl_dec;
					n_halt  = !more;
					n_pos   = endblk ? 16'd0 : e_pos + 16'd1;
					n_phase = 1'b0;
				end
			end else if (e_halt) begin
				act     = 1'b1;
				consume = 1'b1;
			end else begin
				unique case (e_pos)
					16'd0: begin
						act     = 1'b1;
						consume = 1'b1;
						n_hlo   = item_byte;
						n_bl    = (e_bl > HDR_BYTES) ? e_bl - HDR_BYTES : 32'd0;
						n_pos   = 16'd1;
					end
					16'd1: begin
						if (slot_free) begin
							act     = 1'b1;
							consume = 1'b1;
							emit    = 1'b1;
							more    = sd_inc < cfg.sample_limit;
							n_pred  = $signed({item_byte, e_hlo});
							res     = '{sample: $signed({item_byte, e_hlo}),
								last_of_byte: 1'b1, final_res: !more};
							n_sd    = sd_inc;
							n_halt  = !more;
							n_pos   = 16'd2;
						end
					end
					16'd2: begin
						act     = 1'b1;
						consume = 1'b1;
						n_idx   = (item_byte > {1'b0, IDX_MAX}) ? IDX_MAX : item_byte[6:0];
						n_pos   = 16'd3;
					end
					16'd3: begin
						act     = 1'b1;
						consume = 1'b1;
						n_pos   = 16'd4;
					end
					default: begin
						if (e_bl == 32'd0) begin
							act     = 1'b1;
							consume = 1'b1;
							n_halt  = 1'b1;
						end else if (slot_free) begin
							// low nibble
							act    = 1'b1;
							emit   = 1'b1;
							n_pred = dec_pred;
							n_idx  = dec_idx;
							n_sd   = sd_inc;
							if (sd_inc >= cfg.sample_limit) begin
								consume = 1'b1;
								n_halt  = 1'b1;
								res     = '{sample: dec_pred, last_of_byte: 1'b1,
									final_res: 1'b1};
							end else begin
								n_phase = 1'b1;
								res     = '{sample: dec_pred, last_of_byte: 1'b0,
									final_res: 1'b0};
							end
						end
					end
				endcase
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_q    <= '0;
			step_index_q   <= '0;
			block_pos_q    <= '0;
			hdr_low_q      <= '0;
			bytes_left_q   <= '0;
			samples_done_q <= '0;
			halted_q       <= 1'b1;
			phase_q        <= 1'b0;
		end else if (act) begin
			predictor_q    <= n_pred;
			step_index_q   <= n_idx;
			block_pos_q    <= n_pos;
			hdr_low_q      <= n_hlo;
			bytes_left_q   <= n_bl;
			samples_done_q <= n_sd;
			halted_q       <= n_halt;
			phase_q        <= n_phase;
		end
	end

	`ASSERT_IMPLY(a_phase_has_item, phase_q, item_valid, "high nibble pending without an item")
	`ASSERT_NEXT(a_final_halts, emit && res.final_res, halted_q, "final sample did not halt")
	`ASSERT_NEXT(a_low_then_high, emit && !res.last_of_byte, phase_q && item_valid, "low nibble not followed by high nibble")
	`ASSERT_ALWAYS(a_idx_range, step_index_q <= IDX_MAX, "step index above table range")

endmodule

`default_nettype wire

FILE: hw/rtl/ima_adpcm_block_decoder.sv
// Mono IMA ADPCM block decoder: one encoded byte in, up to two 16-bit samples out. A byte
// is taken into an input register and decoded by a single nibble decoder into an output
// register, with a separate valid/ready handshake on each side. Header bytes yield at most
// the header sample; a data byte is decoded a nibble at a time, low nibble first, one
// sample per cycle while the output register is free. A new byte enters the input register
// once the current one is consumed; a sample reaches the output in the cycle after its
// nibble is decoded. Configuration (block_align, sample_limit, byte_count at byte addresses
// 0, 4, 8) must be written over the APB port while the decoder is idle (not enforced).
// Depends on ima_pkg, ima_ctrl and ima_nibble.
`default_nettype none

module ima_adpcm_block_decoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// byte input
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               start_req,
	// sample output
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      sample,
	output logic                    last_of_byte,
	output logic                    final_res
);
	import ima_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;
	logic                 consume, emit, slot_free, out_valid_q;
	res_t                 res, res_q;

	// Register access
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BLOCK_ALIGN:  cfg_q.block_align  <= pwdata[15:0];
				REG_SAMPLE_LIMIT: cfg_q.sample_limit <= pwdata;
				REG_BYTE_COUNT:   cfg_q.byte_count   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_ALIGN:  prdata = {16'd0, cfg_q.block_align};
			REG_SAMPLE_LIMIT: prdata = cfg_q.sample_limit;
			REG_BYTE_COUNT:   prdata = cfg_q.byte_count;
			default:          prdata = 32'd0;
		endcase
	end

	// Input register
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= start_req;
		end
	end

	ima_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (valid_s1),
		.item_byte  (byte_s1),
		.item_start (start_s1),
		.slot_free  (slot_free),
		.consume    (consume),
		.emit       (emit),
		.res        (res)
	);

	// Output register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = res_q.sample;
	assign last_of_byte = res_q.last_of_byte;
	assign final_res    = res_q.final_res;

endmodule

`default_nettype wire
